### rtl/tlbpt_pkg.sv
// Package for the TLB and page-table address translator.
// Holds sizes, field widths, status codes and the controller command type.
// Has no dependencies; every other file of the block depends on it.
`timescale 1ns / 1ps

package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;
  localparam int OFFSET_BITS = 8;

  localparam int ADDR_W    = 16;
  localparam int FRAME_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 32;
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int TFRAME_W  = $clog2(FRAME_COUNT);
  localparam int NFF_W     = $clog2(FRAME_COUNT + 1);
  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam status_t ST_TLB_HIT   = 2'd0;
  localparam status_t ST_TABLE_HIT = 2'd1;
  localparam status_t ST_FAULT     = 2'd2;
  localparam status_t ST_NO_FRAME  = 2'd3;

  typedef struct packed {
    logic capture;
    logic commit;
  } tlbpt_cmd_t;

endpackage

### rtl/tlbpt_if.sv
// Valid/ready channel interfaces for the translator's input and result streams.
// Depends on tlbpt_pkg for the payload types.
`timescale 1ns / 1ps

interface tlbpt_in_if;
  logic                  valid;
  logic                  ready;
  tlbpt_pkg::addr_t      logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

interface tlbpt_out_if;
  logic                  valid;
  logic                  ready;
  tlbpt_pkg::addr_t      physical_address;
  tlbpt_pkg::frame_t     frame_number;
  tlbpt_pkg::status_t    status;
  tlbpt_pkg::count_t     tlb_hit_count;
  tlbpt_pkg::count_t     fault_count;

  modport source (output valid, output physical_address, output frame_number,
                  output status, output tlb_hit_count, output fault_count,
                  input ready);
  modport sink (input valid, input physical_address, input frame_number,
                input status, input tlb_hit_count, input fault_count,
                output ready);
endinterface

### rtl/tlbpt_ctrl.sv
// Controller of the translator: a two-state machine and the result valid flag.
// Issues capture and commit commands to tlbpt_datapath; depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlbpt_pkg::tlbpt_cmd_t cmd
);
  import tlbpt_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/tlbpt_datapath.sv
// Datapath of the translator: TLB registers, page-table memory, frame
// allocator, hit and fault counters and the result register.
// Driven by commands from tlbpt_ctrl; depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlbpt_pkg::tlbpt_cmd_t cmd,
  input  tlbpt_pkg::addr_t      in_logical_address,
  output tlbpt_pkg::addr_t      out_physical_address,
  output tlbpt_pkg::frame_t     out_frame_number,
  output tlbpt_pkg::status_t    out_status,
  output tlbpt_pkg::count_t     out_tlb_hit_count,
  output tlbpt_pkg::count_t     out_fault_count
);
  import tlbpt_pkg::*;

  logic [TFRAME_W-1:0]  table_mem [PAGE_COUNT];
  logic [TFRAME_W-1:0]  table_rdata_r;
  logic [PAGE_COUNT-1:0] table_valid_r;

  logic [PAGE_W-1:0]    tlb_tag_r   [TLB_ENTRIES];
  logic [TFRAME_W-1:0]  tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [TLB_IDX_W-1:0] repl_ptr_r, repl_ptr_nxt;

  logic [NFF_W-1:0]     nff_r;
  count_t               hit_cnt_r, hit_cnt_nxt;
  count_t               miss_cnt_r, miss_cnt_nxt;
  addr_t                addr_r;

  addr_t                phys_r, phys_nxt;
  frame_t               frame_out_r, frame_out_nxt;
  status_t              status_r, status_nxt;

  logic [PAGE_W-1:0]      page, in_page;
  logic [OFFSET_BITS-1:0] offset;
  logic                   tlb_found;
  logic [TLB_IDX_W-1:0]   tlb_idx;
  logic [TFRAME_W-1:0]    frame;
  logic                   fill_tlb;
  logic                   alloc;

  assign in_page = PAGE_W'(in_logical_address >> OFFSET_BITS);
  assign page    = PAGE_W'(addr_r >> OFFSET_BITS);
  assign offset  = addr_r[OFFSET_BITS-1:0];

  always_comb begin
    tlb_found = 1'b0;
    tlb_idx   = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!tlb_found && tlb_valid_r[i] && (tlb_tag_r[i] == page)) begin
        tlb_found = 1'b1;
        tlb_idx   = TLB_IDX_W'(i);
      end
    end
  end

  always_comb begin
    fill_tlb     = 1'b0;
    alloc        = 1'b0;
    frame        = '0;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (tlb_found) begin
      status_nxt  = ST_TLB_HIT;
      frame       = tlb_frame_r[tlb_idx];
      hit_cnt_nxt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
    end else if (table_valid_r[page]) begin
      status_nxt = ST_TABLE_HIT;
      frame      = table_rdata_r;
      fill_tlb   = 1'b1;
    end else if (nff_r >= NFF_W'(FRAME_COUNT)) begin
      status_nxt   = ST_NO_FRAME;
      miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;
    end else begin
      status_nxt   = ST_FAULT;
      frame        = TFRAME_W'(nff_r);
      alloc        = 1'b1;
      fill_tlb     = 1'b1;
      miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;
    end
    if (status_nxt == ST_NO_FRAME) begin
      phys_nxt      = '0;
      frame_out_nxt = '0;
    end else begin
      phys_nxt      = ADDR_W'((32'(frame) << OFFSET_BITS) | 32'(offset));
      frame_out_nxt = FRAME_W'(frame);
    end
    repl_ptr_nxt = (repl_ptr_r == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : repl_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r        <= in_logical_address;
      table_rdata_r <= table_mem[in_page];
    end
    if (cmd.commit && alloc) begin
      table_mem[page] <= frame;
    end
    if (cmd.commit && fill_tlb) begin
      tlb_tag_r[repl_ptr_r]   <= page;
      tlb_frame_r[repl_ptr_r] <= frame;
    end
    if (cmd.commit) begin
      phys_r      <= phys_nxt;
      frame_out_r <= frame_out_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_valid_r <= '0;
      tlb_valid_r   <= '0;
      repl_ptr_r    <= '0;
      nff_r         <= '0;
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (alloc) begin
        table_valid_r[page] <= 1'b1;
        nff_r               <= nff_r + 1'b1;
      end
      if (fill_tlb) begin
        tlb_valid_r[repl_ptr_r] <= 1'b1;
        repl_ptr_r              <= repl_ptr_nxt;
      end
    end
  end

  assign out_physical_address = phys_r;
  assign out_frame_number     = frame_out_r;
  assign out_status           = status_r;
  assign out_tlb_hit_count    = hit_cnt_r;
  assign out_fault_count      = miss_cnt_r;

endmodule

### rtl/tlb_page_table_translator.sv
// Top level of the TLB and page-table address translator.
// Joins tlbpt_ctrl and tlbpt_datapath; depends on tlbpt_pkg and tlbpt_if.
// Each address passes the accept state, which reads the page-table memory, and
// then the lookup state, which compares the TLB, resolves the page and writes
// the TLB, page table and counters back; no new address is accepted until the
// lookup completes. A result waits in the output register until taken. While
// the register is full, one more address can be accepted, but its lookup holds
// and no further address is accepted until that lookup completes. Result
// status is TLB hit, page-table hit, page fault with a new frame, or out of
// frames, and every result carries the saturating hit and fault counts.
`timescale 1ns / 1ps

module tlb_page_table_translator (
  input  logic        clk,
  input  logic        rst_n,
  tlbpt_in_if.sink    in_ch,
  tlbpt_out_if.source out_ch
);
  import tlbpt_pkg::*;

  tlbpt_cmd_t cmd;

  tlbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tlbpt_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_logical_address   (in_ch.logical_address),
    .out_physical_address (out_ch.physical_address),
    .out_frame_number     (out_ch.frame_number),
    .out_status           (out_ch.status),
    .out_tlb_hit_count    (out_ch.tlb_hit_count),
    .out_fault_count      (out_ch.fault_count)
  );

endmodule

### rtl/tlbpt_checker.sv
// Port-level checker for the translator and the bind that attaches it.
// Depends on tlbpt_pkg and on the top level tlb_page_table_translator.
`timescale 1ns / 1ps

module tlbpt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tlbpt_pkg::addr_t   physical_address,
  input tlbpt_pkg::frame_t  frame_number,
  input tlbpt_pkg::status_t status
);
  import tlbpt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(physical_address))
    else $error("Result dropped or changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while a lookup was in progress.");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_NO_FRAME) |-> (physical_address == '0) && (frame_number == '0))
    else $error("Out-of-frames result carries a nonzero address.");

  a_frame_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_NO_FRAME)
      |-> (physical_address[ADDR_W-1:OFFSET_BITS] == frame_number))
    else $error("Physical address does not match the frame number.");

endmodule

bind tlb_page_table_translator tlbpt_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .physical_address (out_ch.physical_address),
  .frame_number     (out_ch.frame_number),
  .status           (out_ch.status)
);
